// ----- hdl/tbha_pkg.sv -----
package tbha_pkg;

   localparam int IDX_W         = 20;
   localparam int VAL_W         = 32;
   localparam int DIF_W         = VAL_W + 1;
   localparam int SQ_W          = 2 * DIF_W;
   localparam int ROOT_W        = DIF_W;
   localparam int REM_W         = ROOT_W + 3;
   localparam int FRAC_W        = 16;
   localparam int QUO_W         = ROOT_W + FRAC_W;
   localparam int RAD_W         = 31;
   localparam int FT_W          = 17;
   localparam int MODE_W        = 2;
   localparam int CSR_W         = 32;
   localparam int CSR_ADDR_W    = 2;
   localparam int P_W           = VAL_W + FT_W;
   localparam int GRID_VERTICES = 1048576;

   localparam logic [CSR_ADDR_W-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RADIUS = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RATE   = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_FTIME  = 2'd3;

   localparam logic [MODE_W-1:0] MODE_FALLOFF = 2'd0;
   localparam logic [MODE_W-1:0] MODE_UNIFORM = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HOLD    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic [VAL_W-1:0] height;
   } tag_type;

endpackage

// ----- hdl/tbha_sqrt.sv -----
module tbha_sqrt
   import tbha_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [SQ_W-1:0]   in_rad,
   input  tag_type           in_tag,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output tag_type           out_tag
);

   logic              valid_ff [ROOT_W];
   logic [SQ_W-1:0]   rad_ff   [ROOT_W];
   logic [REM_W-1:0]  rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   tag_type           tag_ff   [ROOT_W];

   // one result bit per stage, two radicand bits consumed
   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      logic              pv;
      logic [SQ_W-1:0]   prad;
      logic [REM_W-1:0]  prem;
      logic [ROOT_W-1:0] proot;
      tag_type           ptag;
      logic [REM_W-1:0]  rem_s_in;
      logic [REM_W-1:0]  trial_in;

      if (i == 0) begin : g_first
         assign pv    = in_valid;
         assign prad  = in_rad;
         assign prem  = '0;
         assign proot = '0;
         assign ptag  = in_tag;
      end else begin : g_next
         assign pv    = valid_ff[i-1];
         assign prad  = rad_ff[i-1];
         assign prem  = rem_ff[i-1];
         assign proot = root_ff[i-1];
         assign ptag  = tag_ff[i-1];
      end

      assign rem_s_in = {prem[REM_W-3:0], prad[SQ_W-1-2*i -: 2]};
      assign trial_in = {{(REM_W-ROOT_W-2){1'b0}}, proot, 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= pv;
         end
         rad_ff[i] <= prad;
         tag_ff[i] <= ptag;
         if (rem_s_in >= trial_in) begin
            rem_ff[i]  <= rem_s_in - trial_in;
            root_ff[i] <= {proot[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff[i]  <= rem_s_in;
            root_ff[i] <= {proot[ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_tag   = tag_ff[ROOT_W-1];

endmodule

// ----- hdl/tbha_div.sv -----
module tbha_div
   import tbha_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [ROOT_W-1:0] in_num,
   input  logic [RAD_W-1:0]  divisor,
   input  tag_type           in_tag,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output tag_type           out_tag
);

   logic              valid_ff [QUO_W];
   logic [ROOT_W-1:0] num_ff   [QUO_W];
   logic [RAD_W-1:0]  rem_ff   [QUO_W];
   logic [QUO_W-1:0]  quo_ff   [QUO_W];
   tag_type           tag_ff   [QUO_W];

   // restoring division of num * 2^16, one quotient bit per stage
   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      logic              pv;
      logic [ROOT_W-1:0] pnum;
      logic [RAD_W-1:0]  prem;
      logic [QUO_W-1:0]  pquo;
      tag_type           ptag;
      logic              nbit;
      logic [RAD_W:0]    rem_s_in;
      logic [RAD_W:0]    diff_in;

      if (j == 0) begin : g_first
         assign pv   = in_valid;
         assign pnum = in_num;
         assign prem = '0;
         assign pquo = '0;
         assign ptag = in_tag;
      end else begin : g_next
         assign pv   = valid_ff[j-1];
         assign pnum = num_ff[j-1];
         assign prem = rem_ff[j-1];
         assign pquo = quo_ff[j-1];
         assign ptag = tag_ff[j-1];
      end

      if (j < ROOT_W) begin : g_numbit
         assign nbit = pnum[ROOT_W-1-j];
      end else begin : g_zerobit
         assign nbit = 1'b0;
      end

      assign rem_s_in = {prem, nbit};
      assign diff_in  = rem_s_in - {1'b0, divisor};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else begin
            valid_ff[j] <= pv;
         end
         num_ff[j] <= pnum;
         tag_ff[j] <= ptag;
         if (rem_s_in >= {1'b0, divisor}) begin
            rem_ff[j] <= diff_in[RAD_W-1:0];
            quo_ff[j] <= {pquo[QUO_W-2:0], 1'b1};
         end else begin
            rem_ff[j] <= rem_s_in[RAD_W-1:0];
            quo_ff[j] <= {pquo[QUO_W-2:0], 1'b0};
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_tag   = tag_ff[QUO_W-1];

endmodule

// ----- hdl/terrain_brush_height_adjust.sv -----
// Throughput: one request per cycle; the 33-stage square root and the
// 49-stage divider each retire one bit per stage and hold most of the pipeline.
// Reset (synchronous) clears all valid bits and loads the register defaults.
// Results appear for one cycle only; the receiver cannot stall them.
module terrain_brush_height_adjust
   import tbha_pkg::*;
#(
   parameter int GRID_VERTICES = tbha_pkg::GRID_VERTICES
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [IDX_W-1:0]       req_vertex_index,
   input  logic signed [VAL_W-1:0] req_vertex_x,
   input  logic signed [VAL_W-1:0] req_vertex_z,
   input  logic signed [VAL_W-1:0] req_vertex_height,
   input  logic signed [VAL_W-1:0] req_center_x,
   input  logic signed [VAL_W-1:0] req_center_z,
   output logic                   rsp_valid,
   output logic [IDX_W-1:0]       rsp_out_index,
   output logic signed [VAL_W-1:0] rsp_new_height,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_W-1:0]       csr_wdata
);

   localparam int FM_W   = QUO_W + 1;
   localparam int PM_W   = P_W - 1;
   localparam int FLO_W  = 25;
   localparam int PLO_W  = 24;
   localparam int PP_W   = FM_W + PM_W;
   localparam int DL_W   = 42;
   localparam int SUM_W  = DL_W + 1;

   logic [MODE_W-1:0]       mode_ff;
   logic [RAD_W-1:0]        radius_ff;
   logic signed [VAL_W-1:0] rate_ff;
   logic [FT_W-1:0]         ftime_ff;
   logic signed [P_W-1:0]   p_ff;
   logic [PM_W-1:0]         pmag_ff;
   logic [RAD_W-1:0]        divisor_in;

   // hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_FALLOFF;
         radius_ff <= RAD_W'(655360);
         rate_ff   <= '0;
         ftime_ff  <= FT_W'(1092);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MODE:   mode_ff   <= csr_wdata[MODE_W-1:0];
            CSR_RADIUS: radius_ff <= csr_wdata[RAD_W-1:0];
            CSR_RATE:   rate_ff   <= csr_wdata;
            CSR_FTIME:  ftime_ff  <= csr_wdata[FT_W-1:0];
            default:    mode_ff   <= mode_ff;
         endcase
      end
   end

   // rate times frame time, refreshed from the static registers
   logic signed [P_W-1:0] p_in;
   assign p_in = P_W'(rate_ff) * P_W'($signed({1'b0, ftime_ff}));
   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      pmag_ff <= p_ff[P_W-1] ? PM_W'(-p_ff) : p_ff[PM_W-1:0];
   end

   // a zero radius divides as one
   assign divisor_in = (radius_ff == '0) ? RAD_W'(1) : radius_ff;

   assign busy = 1'b0;

   // stage 1: coordinate differences and magnitudes
   logic                   s1_valid_ff;
   tag_type                s1_tag_ff;
   logic [DIF_W-1:0]       s1_adx_ff, s1_adz_ff;
   logic signed [DIF_W-1:0] dx_in, dz_in;
   assign dx_in = DIF_W'(req_vertex_x) - DIF_W'(req_center_x);
   assign dz_in = DIF_W'(req_vertex_z) - DIF_W'(req_center_z);
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
      s1_tag_ff <= '{idx: req_vertex_index, height: req_vertex_height};
      s1_adx_ff <= dx_in[DIF_W-1] ? DIF_W'(-dx_in) : dx_in;
      s1_adz_ff <= dz_in[DIF_W-1] ? DIF_W'(-dz_in) : dz_in;
   end

   // stage 2: squares
   logic            s2_valid_ff;
   tag_type         s2_tag_ff;
   logic [SQ_W-1:0] s2_sqx_ff, s2_sqz_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_tag_ff <= s1_tag_ff;
      s2_sqx_ff <= SQ_W'(s1_adx_ff) * SQ_W'(s1_adx_ff);
      s2_sqz_ff <= SQ_W'(s1_adz_ff) * SQ_W'(s1_adz_ff);
   end

   // stage 3: sum of squares
   logic            s3_valid_ff;
   tag_type         s3_tag_ff;
   logic [SQ_W-1:0] s3_sum_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_tag_ff <= s2_tag_ff;
      s3_sum_ff <= s2_sqx_ff + s2_sqz_ff;
   end

   logic              rt_valid;
   logic [ROOT_W-1:0] rt_root;
   tag_type           rt_tag;
   tbha_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_rad    (s3_sum_ff),
      .in_tag    (s3_tag_ff),
      .out_valid (rt_valid),
      .out_root  (rt_root),
      .out_tag   (rt_tag)
   );

   logic             dv_valid;
   logic [QUO_W-1:0] dv_quo;
   tag_type          dv_tag;
   tbha_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rt_valid),
      .in_num    (rt_root),
      .divisor   (divisor_in),
      .in_tag    (rt_tag),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_tag   (dv_tag)
   );

   // stage 4: falloff magnitude and product sign
   logic                  s4_valid_ff;
   tag_type               s4_tag_ff;
   logic [FM_W-1:0]       s4_fmag_ff;
   logic                  s4_neg_ff;
   logic signed [FM_W:0]  f_in;
   assign f_in = (FM_W+1)'(65536) - (FM_W+1)'(dv_quo);
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= dv_valid;
      end
      s4_tag_ff  <= dv_tag;
      s4_fmag_ff <= f_in[FM_W] ? FM_W'(-f_in) : f_in[FM_W-1:0];
      s4_neg_ff  <= f_in[FM_W] ^ p_ff[P_W-1];
   end

   // stage 5: partial products of falloff and rate
   logic                  s5_valid_ff;
   tag_type               s5_tag_ff;
   logic                  s5_neg_ff;
   logic [PP_W-1:0]       s5_pp_ff [4];
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
      s5_tag_ff   <= s4_tag_ff;
      s5_neg_ff   <= s4_neg_ff;
      s5_pp_ff[0] <= PP_W'(s4_fmag_ff[FLO_W-1:0] * pmag_ff[PLO_W-1:0]);
      s5_pp_ff[1] <= PP_W'(s4_fmag_ff[FLO_W-1:0] * pmag_ff[PM_W-1:PLO_W]) << PLO_W;
      s5_pp_ff[2] <= PP_W'(s4_fmag_ff[FM_W-1:FLO_W] * pmag_ff[PLO_W-1:0]) << FLO_W;
      s5_pp_ff[3] <= PP_W'(s4_fmag_ff[FM_W-1:FLO_W] * pmag_ff[PM_W-1:PLO_W])
                     << (FLO_W + PLO_W);
   end

   // stage 6: full product
   logic            s6_valid_ff;
   tag_type         s6_tag_ff;
   logic            s6_neg_ff;
   logic [PP_W-1:0] s6_prod_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= s5_valid_ff;
      end
      s6_tag_ff  <= s5_tag_ff;
      s6_neg_ff  <= s5_neg_ff;
      s6_prod_ff <= (s5_pp_ff[0] + s5_pp_ff[1]) + (s5_pp_ff[2] + s5_pp_ff[3]);
   end

   // stage 7: delta by mode (floor and clamp in falloff), zero delta beyond the grid
   logic                    s7_valid_ff;
   tag_type                 s7_tag_ff;
   logic signed [DL_W-1:0]  s7_delta_ff;
   logic                    big_in;
   logic [DL_W-2:0]         q_in;
   logic [DL_W-2:0]         qc_in;
   logic signed [DL_W-1:0]  delta_in;
   logic                    in_grid_in;
   assign big_in = |s6_prod_ff[PP_W-1:VAL_W+DL_W-2];
   assign q_in   = {1'b0, s6_prod_ff[VAL_W+DL_W-3:VAL_W]} +
                   (DL_W-1)'(s6_neg_ff && (|s6_prod_ff[VAL_W-1:0]));
   assign qc_in  = big_in ? (DL_W-1)'(1) << (DL_W-2) : q_in;
   assign in_grid_in = {{(32-IDX_W){1'b0}}, s6_tag_ff.idx} < 32'(GRID_VERTICES);
   always_comb begin
      case (mode_ff)
         MODE_FALLOFF: delta_in = s6_neg_ff ? -$signed({1'b0, qc_in}) : $signed({1'b0, qc_in});
         MODE_UNIFORM: delta_in = DL_W'(p_ff >>> FRAC_W);
         default:      delta_in = '0;
      endcase
      if (!in_grid_in) begin
         delta_in = '0;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else begin
         s7_valid_ff <= s6_valid_ff;
      end
      s7_tag_ff   <= s6_tag_ff;
      s7_delta_ff <= delta_in;
   end

   // stage 8: add and saturate into the result register
   logic signed [SUM_W-1:0] sum_in;
   logic signed [VAL_W-1:0] sat_in;
   assign sum_in = SUM_W'($signed(s7_tag_ff.height)) + SUM_W'(s7_delta_ff);
   always_comb begin
      if (sum_in > SUM_W'(32'sh7FFF_FFFF)) begin
         sat_in = 32'sh7FFF_FFFF;
      end else if (sum_in < -SUM_W'(33'sh0_8000_0000)) begin
         sat_in = 32'sh8000_0000;
      end else begin
         sat_in = sum_in[VAL_W-1:0];
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= s7_valid_ff;
      end
      rsp_out_index  <= s7_tag_ff.idx;
      rsp_new_height <= sat_in;
   end

endmodule

// ----- tb/tb_terrain_brush_height_adjust.sv -----
module tb_terrain_brush_height_adjust;
   import tbha_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int  WATCHDOG_LIMIT = 5000;
   localparam int  DRAIN_CYCLES   = 120;
   localparam int  RAND_PHASES    = 10;
   localparam int  PHASE_ITEMS    = 168;
   localparam logic signed [127:0] DELTA_MAX = 128'sh100_0000_0000;

   typedef struct packed {
      logic [IDX_W-1:0]        idx;
      logic signed [VAL_W-1:0] x;
      logic signed [VAL_W-1:0] z;
      logic signed [VAL_W-1:0] h;
      logic signed [VAL_W-1:0] cx;
      logic signed [VAL_W-1:0] cz;
   } vertex_type;

   typedef struct packed {
      logic [IDX_W-1:0]        idx;
      logic signed [VAL_W-1:0] height;
   } adjusted_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic rsp_valid;
   logic [IDX_W-1:0] rsp_out_index;
   logic signed [VAL_W-1:0] rsp_new_height;
   logic csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = CSR_MODE;
   logic [CSR_W-1:0] csr_wdata = '0;

   vertex_type cur_vertex = '0;

   // brush registers as the block should hold them
   logic [MODE_W-1:0]       brush_mode   = MODE_FALLOFF;
   logic [RAD_W-1:0]        brush_radius = 31'd655360;
   logic signed [VAL_W-1:0] height_rate  = '0;
   logic [FT_W-1:0]         frame_time   = 17'd1092;

   vertex_type   vertex_queue[$];
   adjusted_type height_queue[$];
   int        gap_left = 0;
   int        gap_max = 13;
   int        mismatches = 0;
   int        idle_cycles = 0;

   always #1 clock = ~clock;

   terrain_brush_height_adjust dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_vertex_index(cur_vertex.idx),
      .req_vertex_x(cur_vertex.x),
      .req_vertex_z(cur_vertex.z),
      .req_vertex_height(cur_vertex.h),
      .req_center_x(cur_vertex.cx),
      .req_center_z(cur_vertex.cz),
      .rsp_valid(rsp_valid),
      .rsp_out_index(rsp_out_index),
      .rsp_new_height(rsp_new_height),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   // predict the new height for one vertex under the current registers
   function automatic adjusted_type adjust_vertex(vertex_type v);
      longint dx, dz, f, p;
      logic [67:0] ax, az, sq, root, trial;
      logic [63:0] q, rad;
      logic signed [127:0] fw, pw, delta, sum;
      adjusted_type res;
      delta = '0;
      p = longint'(height_rate) * longint'(frame_time);
      if (brush_mode == MODE_FALLOFF) begin
         dx = longint'(v.x) - longint'(v.cx);
         dz = longint'(v.z) - longint'(v.cz);
         ax = 68'((dx < 0) ? -dx : dx);
         az = 68'((dz < 0) ? -dz : dz);
         sq = ax * ax + az * az;
         root = '0;
         for (int b = 33; b >= 0; b--) begin
            trial = root | (68'd1 << b);
            if (trial * trial <= sq) root = trial;
         end
         rad = (brush_radius == 0) ? 64'd1 : 64'(brush_radius);
         q = (root[63:0] << 16) / rad;
         f = 65536 - longint'(q);
         fw = 128'(f);
         pw = 128'(p);
         delta = (fw * pw) >>> 32;
      end else if (brush_mode == MODE_UNIFORM) begin
         pw = 128'(p);
         delta = pw >>> 16;
      end
      // clamp huge changes; out-of-grid vertices keep their height
      if (delta > DELTA_MAX) delta = DELTA_MAX;
      if (delta < -DELTA_MAX) delta = -DELTA_MAX;
      if (int'(v.idx) >= GRID_VERTICES) delta = '0;
      fw = 128'(v.h);
      sum = fw + delta;
      if (sum > 128'sh7FFF_FFFF) sum = 128'sh7FFF_FFFF;
      if (sum < -128'sh8000_0000) sum = -128'sh8000_0000;
      res.idx = v.idx;
      res.height = sum[31:0];
      return res;
   endfunction

   // request driver: present queued vertices, draw a gap after each one
   always @(posedge clock) begin
      int w;
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (start && !busy) begin
         height_queue.push_back(adjust_vertex(cur_vertex));
         w = $urandom_range(0, gap_max);
         if (w == 0 && vertex_queue.size() != 0) begin
            cur_vertex <= vertex_queue.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
            gap_left <= w;
         end
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (vertex_queue.size() != 0) begin
            cur_vertex <= vertex_queue.pop_front();
            start <= 1'b1;
         end
      end
   end

   // result monitor: compare each strobe with the oldest prediction
   always @(posedge clock) begin
      adjusted_type exp_res;
      if (!reset && rsp_valid) begin
         if (height_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result idx=%0d height=%0d",
                        rsp_out_index, rsp_new_height);
         end else begin
            exp_res = height_queue.pop_front();
            if (rsp_out_index !== exp_res.idx || rsp_new_height !== exp_res.height) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected idx=%0d height=%0d, got idx=%0d height=%0d",
                           exp_res.idx, exp_res.height, rsp_out_index, rsp_new_height);
            end
         end
      end
   end

   // watchdog: count cycles with no request and no result accepted
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      case (addr)
         CSR_MODE:   brush_mode   = data[MODE_W-1:0];
         CSR_RADIUS: brush_radius = data[RAD_W-1:0];
         CSR_RATE:   height_rate  = data;
         default:    frame_time   = data[FT_W-1:0];
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_brush(logic [1:0] mode, logic [30:0] radius, logic [31:0] rate,
                            logic [16:0] ftime);
      write_reg(CSR_MODE, 32'(mode));
      write_reg(CSR_RADIUS, 32'(radius));
      write_reg(CSR_RATE, rate);
      write_reg(CSR_FTIME, 32'(ftime));
   endtask

   // hold until every request went in and every result came back
   task automatic wait_drained();
      do @(negedge clock);
      while (vertex_queue.size() != 0 || start || height_queue.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_vertex(int idx, int x, int z, int h, int cx, int cz);
      vertex_type v;
      v.idx = idx[IDX_W-1:0];
      v.x = x;
      v.z = z;
      v.h = h;
      v.cx = cx;
      v.cz = cz;
      vertex_queue.push_back(v);
   endtask

   // mostly vertices around the centre, some anywhere on the plane
   task automatic add_random_vertex();
      vertex_type v;
      int span;
      v.idx = IDX_W'($urandom());
      v.cx = $urandom();
      v.cz = $urandom();
      span = (brush_radius > 31'h0100_0000) ? 32'h0100_0000 : int'(brush_radius) + 1;
      if ($urandom_range(0, 3) == 0) begin
         v.x = $urandom();
         v.z = $urandom();
      end else begin
         v.x = v.cx + int'($urandom_range(0, 2 * span)) - span;
         v.z = v.cz + int'($urandom_range(0, 2 * span)) - span;
      end
      case ($urandom_range(0, 5))
         0: v.h = 32'h7FFF_FFFF - $urandom_range(0, 1 << 20);
         1: v.h = 32'h8000_0000 + $urandom_range(0, 1 << 20);
         default: v.h = $urandom();
      endcase
      vertex_queue.push_back(v);
   endtask

   initial begin
      logic [1:0]  mode;
      logic [30:0] radius;
      logic [31:0] rate;
      logic [16:0] ftime;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // falloff at full rate: centre hit, edges of the plane, far vertex
      set_brush(MODE_FALLOFF, 31'd655360, 32'h7FFF_FFFF, 17'd65536);
      add_vertex(0, 0, 0, 0, 0, 0);
      add_vertex(1048575, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000);
      add_vertex(5, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_vertex(7, 655360, 0, 1000, 0, 0);
      add_vertex(8, 327680, 327680, -1000, 0, 0);
      add_vertex(9, 1310720, 0, 32'h7FFF_0000, 0, 0);
      wait_drained();

      // zero radius, most negative rate, longest frame time: huge change
      set_brush(MODE_FALLOFF, 31'd0, 32'h8000_0000, 17'h1FFFF);
      add_vertex(10, 0, 0, 0, 0, 0);
      add_vertex(11, 65536, 0, 32'h7FFF_FFFF, 0, 0);
      add_vertex(12, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
      add_vertex(13, 1, 0, 32'h8000_0000, 0, 0);
      wait_drained();

      // uniform raise at both rate extremes
      set_brush(MODE_UNIFORM, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 17'h1FFFF);
      add_vertex(20, 0, 0, 32'h7FFF_FFFF, 0, 0);
      add_vertex(21, 0, 0, 0, 0, 0);
      wait_drained();
      set_brush(MODE_UNIFORM, 31'd1, 32'h8000_0000, 17'h1FFFF);
      add_vertex(22, 0, 0, 32'h8000_0000, 0, 0);
      add_vertex(23, 0, 0, 12345, 0, 0);
      wait_drained();

      // unused modes leave the height alone
      set_brush(MODE_HOLD, 31'd655360, 32'h7FFF_FFFF, 17'd65536);
      add_vertex(30, 0, 0, 777, 0, 0);
      add_vertex(31, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 0);
      wait_drained();
      set_brush(MODE_SPARE, 31'd655360, 32'h7FFF_FFFF, 17'd65536);
      add_vertex(32, 0, 0, -777, 0, 0);
      add_vertex(33, 0, 0, 32'h7FFF_FFFF, 0, 0);
      wait_drained();

      // random phases, some without request gaps
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case ($urandom_range(0, 7))
            0: mode = MODE_UNIFORM;
            1: mode = ($urandom_range(0, 1) == 0) ? MODE_HOLD : MODE_SPARE;
            default: mode = MODE_FALLOFF;
         endcase
         case ($urandom_range(0, 4))
            0: radius = 31'd1;
            1: radius = 31'h7FFF_FFFF;
            2: radius = RAD_W'($urandom());
            default: radius = RAD_W'($urandom_range(1 << 12, 1 << 24));
         endcase
         case ($urandom_range(0, 4))
            0: rate = 32'h7FFF_FFFF;
            1: rate = 32'h8000_0000;
            default: rate = $urandom();
         endcase
         case ($urandom_range(0, 3))
            0: ftime = 17'd65536;
            1: ftime = 17'd0;
            default: ftime = FT_W'($urandom());
         endcase
         gap_max = (ph % 4 == 3) ? 0 : 13;
         set_brush(mode, radius, rate, ftime);
         for (int i = 0; i < PHASE_ITEMS; i++) add_random_vertex();
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (height_queue.size() != 0) mismatches++;
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/tbha_pkg.sv
hdl/tbha_sqrt.sv
hdl/tbha_div.sv
hdl/terrain_brush_height_adjust.sv
tb/tb_terrain_brush_height_adjust.sv
